// ===== sv/palette_dictionary_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// Palette dictionary encoder: assertion macros
// Shared property forms for the checker; one use per line.
// ----------------------------------------------------------------------------
`ifndef PALETTE_DICTIONARY_ENCODER_DEFINES_SVH
`define PALETTE_DICTIONARY_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define PDE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("palette encoder: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define PDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("palette encoder: next-cycle check failed");

`endif

// ===== sv/pde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette dictionary encoder package
// Widths, palette capacity and the item type shared by the block's files.
// ----------------------------------------------------------------------------
package pde_pkg;

    localparam int PALETTE_DEPTH = 256;                      // 2 .. 256 entries
    localparam int PDE_AW        = $clog2(PALETTE_DEPTH);    // palette address
    localparam int PDE_CW        = $clog2(PALETTE_DEPTH + 1); // entry count

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 8;
    localparam int SIZE_W  = 9;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [VALUE_W-1:0] block_value;
        logic               chunk_end;
    } pde_item_t;

endpackage

// ===== sv/pde_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette dictionary encoder stream interfaces
// Valid/ready channels for block values in and palette results out.
// ----------------------------------------------------------------------------
interface pde_in_if;
    import pde_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] block_value;
    logic               chunk_end;

    modport source (output valid, output block_value, output chunk_end, input ready);
    modport sink   (input valid, input block_value, input chunk_end, output ready);
endinterface

interface pde_out_if;
    import pde_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] palette_index;
    logic               new_entry;
    logic [VALUE_W-1:0] entry_value;
    logic               palette_overflow;
    logic [SIZE_W-1:0]  palette_size;
    logic               chunk_done;

    modport source (
        output valid, output palette_index, output new_entry, output entry_value,
        output palette_overflow, output palette_size, output chunk_done,
        input  ready
    );
    modport sink (
        input  valid, input palette_index, input new_entry, input entry_value,
        input  palette_overflow, input palette_size, input chunk_done,
        output ready
    );
endinterface

// ===== sv/pde_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette encoder front end
// Accept block values and hold them in a short queue for the back end.
// ----------------------------------------------------------------------------
module pde_front (
    input  logic              clk,
    input  logic              rst_n,
    pde_in_if.sink            blk_in,
    output logic              q_valid,
    output pde_pkg::pde_item_t q_item,
    input  logic              q_pop
);
    import pde_pkg::*;

    pde_item_t           slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] fill_reg,   fill_next;
    logic                push;
    logic                pop;

    assign blk_in.ready = (fill_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign push         = blk_in.valid && blk_in.ready;
    assign q_valid      = (fill_reg != '0);
    assign pop          = q_pop && q_valid;
    assign q_item       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        // advance pointers with wrap at the queue depth
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage carries payload only
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{block_value: blk_in.block_value,
                                      chunk_end:   blk_in.chunk_end};
        end
    end

endmodule

// ===== sv/pde_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette encoder back end
// Scan the palette memory for a match, append or flag overflow, drive result.
// ----------------------------------------------------------------------------
module pde_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  pde_pkg::pde_item_t q_item,
    output logic              q_pop,
    pde_out_if.source         res_out
);
    import pde_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE
    } state_t;

    logic [VALUE_W-1:0] mem [PALETTE_DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    state_t             state_reg,     state_next;
    pde_item_t          item_reg,      item_next;
    logic [PDE_CW-1:0]  count_reg,     count_next;
    logic [PDE_CW-1:0]  issue_reg,     issue_next;
    logic               cmp_vld_reg,   cmp_vld_next;
    logic [PDE_AW-1:0]  cmp_idx_reg,   cmp_idx_next;
    logic               hit_reg,       hit_next;
    logic [PDE_AW-1:0]  hit_idx_reg,   hit_idx_next;

    logic               out_vld_reg,   out_vld_next;
    logic [INDEX_W-1:0] out_idx_reg,   out_idx_next;
    logic               out_new_reg,   out_new_next;
    logic [VALUE_W-1:0] out_val_reg,   out_val_next;
    logic               out_ovf_reg,   out_ovf_next;
    logic [SIZE_W-1:0]  out_size_reg,  out_size_next;
    logic               out_done_reg,  out_done_next;

    logic               out_free;
    logic               issue;
    logic               match;
    logic               last_cmp;
    logic               room;
    logic               commit;
    logic               wr_en;
    logic [PDE_CW-1:0]  size_after;

    assign out_free = !out_vld_reg || res_out.ready;
    assign issue    = (state_reg == S_SCAN) && (issue_reg < count_reg);
    assign match    = cmp_vld_reg && (rdata_reg == item_reg.block_value);
    assign last_cmp = cmp_vld_reg && (PDE_CW'(cmp_idx_reg) == count_reg - PDE_CW'(1));
    assign room     = count_reg < PDE_CW'(PALETTE_DEPTH);
    assign commit   = (state_reg == S_RESOLVE) && out_free;
    assign wr_en    = commit && !hit_reg && room;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    assign size_after = (!hit_reg && room) ? count_reg + PDE_CW'(1) : count_reg;

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        cmp_vld_next  = issue;
        cmp_idx_next  = issue_reg[PDE_AW-1:0];
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        out_vld_next  = out_vld_reg && !res_out.ready;
        out_idx_next  = out_idx_reg;
        out_new_next  = out_new_reg;
        out_val_next  = out_val_reg;
        out_ovf_next  = out_ovf_reg;
        out_size_next = out_size_reg;
        out_done_next = out_done_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    item_next  = q_item;
                    issue_next = '0;
                    hit_next   = 1'b0;
                    state_next = (count_reg == '0) ? S_RESOLVE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    issue_next = issue_reg + PDE_CW'(1);
                end
                // first match wins; a compare of the last entry ends the scan
                if (match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    state_next   = S_RESOLVE;
                end
                else if (last_cmp)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_new_next  = !hit_reg && room;
                    out_ovf_next  = !hit_reg && !room;
                    out_val_next  = item_reg.block_value;
                    out_done_next = item_reg.chunk_end;
                    out_size_next = SIZE_W'(size_after);
                    if (hit_reg)
                    begin
                        out_idx_next = INDEX_W'(hit_idx_reg);
                    end
                    else if (room)
                    begin
                        out_idx_next = INDEX_W'(count_reg[PDE_AW-1:0]);
                    end
                    else
                    begin
                        out_idx_next = '0;
                    end
                    count_next = item_reg.chunk_end ? '0 : size_after;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            item_reg     <= '0;
            count_reg    <= '0;
            issue_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_idx_reg  <= '0;
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
            out_vld_reg  <= 1'b0;
            out_idx_reg  <= '0;
            out_new_reg  <= 1'b0;
            out_val_reg  <= '0;
            out_ovf_reg  <= 1'b0;
            out_size_reg <= '0;
            out_done_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            item_reg     <= item_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            cmp_vld_reg  <= cmp_vld_next;
            cmp_idx_reg  <= cmp_idx_next;
            hit_reg      <= hit_next;
            hit_idx_reg  <= hit_idx_next;
            out_vld_reg  <= out_vld_next;
            out_idx_reg  <= out_idx_next;
            out_new_reg  <= out_new_next;
            out_val_reg  <= out_val_next;
            out_ovf_reg  <= out_ovf_next;
            out_size_reg <= out_size_next;
            out_done_reg <= out_done_next;
        end
    end

    // palette store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[PDE_AW-1:0]] <= item_reg.block_value;
        end
        rdata_reg <= mem[issue_reg[PDE_AW-1:0]];
    end

    assign res_out.valid            = out_vld_reg;
    assign res_out.palette_index    = out_idx_reg;
    assign res_out.new_entry        = out_new_reg;
    assign res_out.entry_value      = out_val_reg;
    assign res_out.palette_overflow = out_ovf_reg;
    assign res_out.palette_size     = out_size_reg;
    assign res_out.chunk_done       = out_done_reg;

endmodule

// ===== sv/palette_dictionary_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette dictionary encoder
// Replaces each 32-bit block value with its index in a per-chunk palette.
// ----------------------------------------------------------------------------
// Each block value transferred on blk_in is looked up in the palette built so
// far in the current chunk. A stored value returns its index; a new value is
// appended at the next index and flagged with new_entry, so a consumer can
// rebuild the palette list from the result stream in order. When the palette
// already holds PALETTE_DEPTH entries a new value is not stored: the result
// carries index 0 with palette_overflow set. palette_size reports the entry
// count after the item, and an item with chunk_end set empties the palette
// once its result is formed (chunk_done echoes it). One result leaves on
// res_out for every value taken in. A value is taken into a two-deep queue
// while the previous one is still being looked up or its result is waiting.
// The lookup walks the palette memory through its single read port, one
// entry a cycle, and skips the walk when the palette is empty; an early
// match ends the walk before the remaining entries. No clearing pass is
// needed after reset: the entry count alone marks what is valid.
// ----------------------------------------------------------------------------
module palette_dictionary_encoder (
    input  logic       clk,
    input  logic       rst_n,
    pde_in_if.sink     blk_in,
    pde_out_if.source  res_out
);
    import pde_pkg::*;

    logic      q_valid;
    logic      q_pop;
    pde_item_t q_item;

    // front end: take transfers and queue them
    pde_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .blk_in (blk_in),
        .q_valid(q_valid),
        .q_item (q_item),
        .q_pop  (q_pop)
    );

    // back end: scan, append or flag overflow, hold the result register
    pde_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_valid(q_valid),
        .q_item (q_item),
        .q_pop  (q_pop),
        .res_out(res_out)
    );

endmodule

// ===== sv/pde_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette encoder port checker
// Checks result consistency and output stall behaviour at the top level.
// ----------------------------------------------------------------------------
`include "palette_dictionary_encoder_defines.svh"

module pde_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [pde_pkg::INDEX_W-1:0]  palette_index,
    input logic                         new_entry,
    input logic                         palette_overflow,
    input logic [pde_pkg::SIZE_W-1:0]   palette_size
);
    import pde_pkg::*;

    logic [SIZE_W-1:0] index_wide;

    assign index_wide = SIZE_W'(palette_index);

    // a stalled result stays put
    `PDE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(palette_index) && $stable(palette_size))
    // overflow only on a full palette, with index 0 and nothing appended
    `PDE_ASSERT_NOW(a_ovf_full, clk, rst_n, out_valid && palette_overflow, palette_index == '0 && !new_entry && palette_size == SIZE_W'(PALETTE_DEPTH))
    // an appended entry is always the newest one
    `PDE_ASSERT_NOW(a_new_last, clk, rst_n, out_valid && new_entry, palette_size == index_wide + SIZE_W'(1))
    // a returned index lies inside the palette
    `PDE_ASSERT_NOW(a_idx_range, clk, rst_n, out_valid && !palette_overflow, index_wide < palette_size)

endmodule

bind palette_dictionary_encoder pde_checker u_pde_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (res_out.valid),
    .out_ready       (res_out.ready),
    .palette_index   (res_out.palette_index),
    .new_entry       (res_out.new_entry),
    .palette_overflow(res_out.palette_overflow),
    .palette_size    (res_out.palette_size)
);

// ===== tb/palette_dictionary_encoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette dictionary encoder testbench
// Drives block values through the encoder and checks every palette result against a
// directed expectation or a behavioural mirror of the per-chunk palette, under random stalls.
// ----------------------------------------------------------------------------
module palette_dictionary_encoder_test;
    import pde_pkg::*;

    // Usable palette size: the depth parameter held to 1 .. 256 entries
    localparam int PALETTE_CAP = (PALETTE_DEPTH > 256) ? 256 :
                                 (PALETTE_DEPTH < 1)   ? 1   : PALETTE_DEPTH;
    localparam int RANDOM_BLOCKS = 1600;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 300;

    typedef struct packed {
        logic [INDEX_W-1:0] palette_index;
        logic               new_entry;
        logic [VALUE_W-1:0] entry_value;
        logic               palette_overflow;
        logic [SIZE_W-1:0]  palette_size;
        logic               chunk_done;
    } palette_result_t;

    // A stimulus row is either a single block or a burst of distinct values
    typedef enum logic {ROW_SINGLE, ROW_BURST} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [VALUE_W-1:0] value;
        logic               last;
        int                 span;
        bit                 typed;
        palette_result_t    want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    pde_in_if  blk_if ();
    pde_out_if res_if ();

    palette_dictionary_encoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .blk_in  (blk_if),
        .res_out (res_if)
    );

    always #5 clk = ~clk;

    // Mirror of the encoder state, updated once per accepted transfer
    logic [VALUE_W-1:0] shadow_values [256];
    int unsigned        shadow_count;

    palette_result_t    coded_blocks [$];   // results still owed by the block
    stim_row_t          directed_rows [$];
    int                 error_count;
    int                 random_sent;
    bit                 steady;             // no idling on either side
    bit                 hold_req;           // ask the receiver for a long hold-off

    // Look a value up in the mirrored palette, append or overflow, and
    // empty the palette after a chunk end once the result is formed.
    function automatic palette_result_t palette_lookup(input logic [VALUE_W-1:0] value,
                                                       input logic last);
        palette_result_t r;
        int unsigned     n;
        int unsigned     i;
        bit              hit;
        r   = '0;
        n   = shadow_count;
        hit = 1'b0;
        for (i = 0; i < n; i++)
        begin
            if (!hit && shadow_values[i] == value)
            begin
                hit             = 1'b1;
                r.palette_index = INDEX_W'(i);
            end
        end
        if (!hit)
        begin
            if (n < PALETTE_CAP)
            begin
                shadow_values[n] = value;
                r.palette_index  = INDEX_W'(n);
                r.new_entry      = 1'b1;
                n++;
            end
            else
            begin
                r.palette_overflow = 1'b1;
            end
        end
        r.entry_value  = value;
        r.palette_size = SIZE_W'(n);
        r.chunk_done   = last;
        shadow_count   = last ? 0 : n;
        return r;
    endfunction

    function automatic palette_result_t make_result(input int idx, input bit fresh,
                                                    input logic [VALUE_W-1:0] value,
                                                    input bit over, input int size,
                                                    input bit last);
        palette_result_t r;
        r.palette_index    = INDEX_W'(idx);
        r.new_entry        = fresh;
        r.entry_value      = value;
        r.palette_overflow = over;
        r.palette_size     = SIZE_W'(size);
        r.chunk_done       = last;
        return r;
    endfunction

    task automatic put_row(input row_kind_t kind, input logic [VALUE_W-1:0] value,
                           input logic last, input int span, input bit typed,
                           input palette_result_t want);
        stim_row_t row;
        row.kind  = kind;
        row.value = value;
        row.last  = last;
        row.span  = span;
        row.typed = typed;
        row.want  = want;
        directed_rows = {directed_rows, row};
    endtask

    // Offer one block, hold it until the transfer, then log the expectation.
    // Entered and left at a rising edge; valid stays high into the next
    // call unless an idle gap drops it.
    task automatic send_block(input logic [VALUE_W-1:0] value, input logic last,
                              input bit typed, input palette_result_t want);
        palette_result_t predicted;
        if (!steady && $urandom_range(99) < 15)
        begin
            blk_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        blk_if.valid       <= 1'b1;
        blk_if.block_value <= value;
        blk_if.chunk_end   <= last;
        do @(posedge clk); while (!blk_if.ready);
        predicted = palette_lookup(value, last);
        coded_blocks = {coded_blocks, (typed ? want : predicted)};
    endtask

    task automatic compare_field(input string name, input logic [VALUE_W-1:0] want,
                                 input logic [VALUE_W-1:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    // A value for a random chunk: mostly random, sometimes an extreme
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            2:       return VALUE_W'(1) << $urandom_range(VALUE_W - 1);
            default: return $urandom;
        endcase
    endfunction

    // One random chunk. Most are short, drawn from a small pool so that
    // hits are common; a few run past a full palette into overflow.
    task automatic random_chunk(input int chunk_no);
        logic [VALUE_W-1:0] pool [$];
        logic [VALUE_W-1:0] value;
        int                 len;
        int                 pool_n;
        int                 k;
        bit                 big;
        big = (chunk_no % 45 == 20);
        if (big)
            len = PALETTE_CAP * 3 / 2 + $urandom_range(10, 40);
        else
            len = $urandom_range(1, 40);
        pool_n = $urandom_range(1, len > 24 ? 24 : len);
        if (!big)
            for (k = 0; k < pool_n; k++)
                pool = {pool, pick_value()};
        for (k = 0; k < len; k++)
        begin
            if (big)
            begin
                // grow the palette mostly with fresh values, revisit the rest
                if (pool.size() == 0 || $urandom_range(99) < 70)
                begin
                    value = $urandom;
                    pool = {pool, value};
                end
                else
                    value = pool[$urandom_range(pool.size() - 1)];
            end
            else if ($urandom_range(9) == 0)
                value = $urandom;             // noise outside the pool
            else
                value = pool[$urandom_range(pool_n - 1)];
            steady = (random_sent >= 700 && random_sent < 1000);
            if (random_sent == 400)
                hold_req = 1'b1;
            send_block(value, k == len - 1, 1'b0, '0);
            random_sent++;
        end
    endtask

    // Receiver: random back-pressure, a quiet stretch, and one long hold-off
    initial
    begin
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                res_if.ready <= steady || ($urandom_range(99) >= 15);
        end
    end

    // Score each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        palette_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (coded_blocks.size() == 0)
            begin
                error_count++;
                $display("%0t ns: unexpected result, expected none, actual value %0h",
                         $time, res_if.entry_value);
            end
            else
            begin
                want = coded_blocks.pop_front();
                compare_field("palette_index", want.palette_index, res_if.palette_index);
                compare_field("new_entry", want.new_entry, res_if.new_entry);
                compare_field("entry_value", want.entry_value, res_if.entry_value);
                compare_field("palette_overflow", want.palette_overflow,
                              res_if.palette_overflow);
                compare_field("palette_size", want.palette_size, res_if.palette_size);
                compare_field("chunk_done", want.chunk_done, res_if.chunk_done);
            end
        end
    end

    // Watchdog, sized well beyond the slowest legal run
    initial
    begin
        #(30_000_000);
        $display("palette_dictionary_encoder_test: done, errors");
        $finish;
    end

    initial
    begin
        int        r;
        int        k;
        stim_row_t row;
        error_count        = 0;
        random_sent        = 0;
        steady             = 1'b0;
        hold_req           = 1'b0;
        shadow_count       = 0;
        rst_n              <= 1'b0;
        blk_if.valid       <= 1'b0;
        blk_if.block_value <= '0;
        blk_if.chunk_end   <= 1'b0;

        // Directed table: extremes, hits, chunk ends, stale entries after a
        // clear, a full palette with overflow, and the top index.
        put_row(ROW_SINGLE, 32'h0000_0000, 1'b0, 1, 1'b1,
                make_result(0, 1, 32'h0000_0000, 0, 1, 0));
        put_row(ROW_SINGLE, 32'hFFFF_FFFF, 1'b0, 1, 1'b1,
                make_result(1, 1, 32'hFFFF_FFFF, 0, 2, 0));
        put_row(ROW_SINGLE, 32'h0000_0000, 1'b0, 1, 1'b1,
                make_result(0, 0, 32'h0000_0000, 0, 2, 0));
        put_row(ROW_SINGLE, 32'hFFFF_FFFF, 1'b0, 1, 1'b1,
                make_result(1, 0, 32'hFFFF_FFFF, 0, 2, 0));
        put_row(ROW_SINGLE, 32'hA5A5_A5A5, 1'b0, 1, 1'b0, '0);
        put_row(ROW_SINGLE, 32'h5A5A_5A5A, 1'b1, 1, 1'b1,
                make_result(3, 1, 32'h5A5A_5A5A, 0, 4, 1));
        // palette was emptied: the stale entry must not hit
        put_row(ROW_SINGLE, 32'hFFFF_FFFF, 1'b0, 1, 1'b1,
                make_result(0, 1, 32'hFFFF_FFFF, 0, 1, 0));
        put_row(ROW_SINGLE, 32'hFFFF_FFFF, 1'b1, 1, 1'b1,
                make_result(0, 0, 32'hFFFF_FFFF, 0, 1, 1));
        put_row(ROW_SINGLE, 32'h1234_5678, 1'b1, 1, 1'b1,
                make_result(0, 1, 32'h1234_5678, 0, 1, 1));
        // fill the palette to the brim
        put_row(ROW_BURST, 32'h8000_0000, 1'b0, PALETTE_CAP, 1'b0, '0);
        put_row(ROW_SINGLE, 32'h7FFF_FFFF, 1'b0, 1, 1'b1,
                make_result(0, 0, 32'h7FFF_FFFF, 1, PALETTE_CAP, 0));
        put_row(ROW_SINGLE, 32'h8000_0000, 1'b0, 1, 1'b1,
                make_result(0, 0, 32'h8000_0000, 0, PALETTE_CAP, 0));
        put_row(ROW_SINGLE, 32'h8000_0000 + PALETTE_CAP - 1, 1'b0, 1, 1'b1,
                make_result(PALETTE_CAP - 1, 0, 32'h8000_0000 + PALETTE_CAP - 1, 0,
                            PALETTE_CAP, 0));
        // overflow on the chunk's last block, then a fresh palette
        put_row(ROW_SINGLE, 32'hDEAD_BEEF, 1'b1, 1, 1'b1,
                make_result(0, 0, 32'hDEAD_BEEF, 1, PALETTE_CAP, 1));
        put_row(ROW_SINGLE, 32'hDEAD_BEEF, 1'b0, 1, 1'b1,
                make_result(0, 1, 32'hDEAD_BEEF, 0, 1, 0));
        put_row(ROW_SINGLE, 32'h0000_0001, 1'b0, 1, 1'b0, '0);
        put_row(ROW_SINGLE, 32'h0000_0001, 1'b1, 1, 1'b1,
                make_result(1, 0, 32'h0000_0001, 0, 2, 1));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < directed_rows.size(); r++)
        begin
            row = directed_rows[r];
            if (row.kind == ROW_BURST)
                for (k = 0; k < row.span; k++)
                    send_block(row.value + k, row.last && (k == row.span - 1), 1'b0, '0);
            else
                send_block(row.value, row.last, row.typed, row.want);
        end

        // Random chunks until enough blocks have gone through
        k = 0;
        while (random_sent < RANDOM_BLOCKS)
        begin
            random_chunk(k);
            k++;
        end
        steady = 1'b0;
        blk_if.valid <= 1'b0;

        // Drain, then give the block time to show any stray result
        while (coded_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("palette_dictionary_encoder_test: done, clean");
        else
            $display("palette_dictionary_encoder_test: done, errors");
        $finish;
    end

endmodule
